[rtl/mpfb_pkg.sv]
// Shared types and constants for the page framebuffer text block.
package mpfb_pkg;

  // Default store sizes
  localparam int FRAME_BYTES_DEF = 1024;
  localparam int FONT_BYTES_DEF  = 1024;

  // Rows per page byte
  localparam int PAGE_ROWS = 8;

  // Datapath widths: byte index, glyph base and modulo working value
  localparam int IDX_W  = 14;
  localparam int BASE_W = 12;
  localparam int MOD_W  = 13;

  // Fixed byte values
  localparam logic [7:0] SUBST_CODE = 8'h3F;
  localparam logic [7:0] FILL_WHITE = 8'hFF;
  localparam logic [7:0] FILL_BLACK = 8'h00;

  typedef enum logic [2:0] {
    OP_FILL    = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_CHAR    = 3'd2,
    OP_FONT_WR = 3'd3,
    OP_READ    = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_GCOLS  = 3'd2,
    CFG_FIRST  = 3'd3,
    CFG_LAST   = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_MOD,
    S_FONT,
    S_GLYPH,
    S_PG_RD,
    S_PG_WR,
    S_RDATA,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic       color;
    logic [7:0] char_code;
    logic [9:0] font_addr;
    logic [7:0] font_byte;
    logic [9:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] done_op;
  } out_item_t;

endpackage

[rtl/mono_page_framebuffer_text_core.sv]
// Top level: page framebuffer with fill, pixel, glyph blit, font write and byte read.
//
// Each transfer on the input channel is one operation and yields one result transfer.
// Operations run one at a time under a small sequencer around a single frame-store
// read-modify-write path; in_ready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next operation is taken.
// Fill writes W*P bytes (W = display_width, P = display_height/8, capped at
// FRAME_BYTES bytes), one byte per cycle; a character blits up to 8 glyph columns
// after 1 + 12-clog2(FONT_BYTES) steps of the shared compare-subtract that reduces
// the glyph base modulo FONT_BYTES, and each column costs a font read plus two
// page-byte read-modify-writes. After reset a clearing pass writes zero to all
// FRAME_BYTES frame bytes, during which no item is taken; configuration writes are
// accepted at any time.
module mono_page_framebuffer_text_core #(
  parameter int FRAME_BYTES = mpfb_pkg::FRAME_BYTES_DEF,
  parameter int FONT_BYTES  = mpfb_pkg::FONT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpfb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mpfb_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  import mpfb_pkg::*;

  localparam int FRAME_AW = $clog2(FRAME_BYTES);
  localparam int FONT_AW  = $clog2(FONT_BYTES);
  localparam int CNT_W    = FRAME_AW + 1;
  localparam int MOD_SH   = (FONT_AW < BASE_W) ? (BASE_W - FONT_AW) : 0;
  localparam int K_W      = (MOD_SH > 0) ? $clog2(MOD_SH + 1) : 1;

  // Mask of the rows of a page that lie within the display height
  function automatic logic [7:0] row_clip(input logic [4:0] page, input logic [6:0] height);
    logic [4:0] hp;
    begin
      hp = {1'b0, height[6:3]};
      if (page < hp) begin
        row_clip = 8'hFF;
      end else if (page == hp) begin
        row_clip = ~(8'hFF << height[2:0]);
      end else begin
        row_clip = 8'h00;
      end
    end
  endfunction

  // Control and item registers
  state_t              state_r, state_nxt;
  in_item_t            item_r;
  logic [7:0]          width_r;
  logic [6:0]          height_r;
  logic [3:0]          gcols_r;
  logic [7:0]          first_r;
  logic [7:0]          last_r;
  logic [CNT_W-1:0]    fill_cnt_r, fill_cnt_nxt;
  logic [CNT_W-1:0]    fill_end_r, fill_end_nxt;
  logic [7:0]          fill_val_r, fill_val_nxt;
  logic                clr_r, clr_nxt;
  logic [MOD_W-1:0]    fa_r, fa_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [3:0]          col_r, col_nxt;
  logic [3:0]          cols_r, cols_nxt;
  logic                pass_r, pass_nxt;
  logic [7:0]          glyph_r, glyph_nxt;
  logic [7:0]          dmask_r, dmask_nxt;
  logic [FRAME_AW-1:0] idx_r, idx_nxt;
  logic                wen_r, wen_nxt;
  logic [7:0]          wmask_r, wmask_nxt;
  logic [7:0]          wbits_r, wbits_nxt;
  logic [7:0]          res_data_r, res_data_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Memory ports
  logic                frame_we;
  logic [FRAME_AW-1:0] frame_waddr;
  logic [7:0]          frame_wdata;
  logic [FRAME_AW-1:0] frame_raddr;
  logic [7:0]          frame_rdata;
  logic                font_we;
  logic [FONT_AW-1:0]  font_waddr;
  logic [7:0]          font_rdata;

  // Shared datapath terms
  logic [IDX_W-1:0]  raddr_ext;
  logic [MOD_W-1:0]  faddr_ext;
  logic [11:0]       fill_n;
  logic [7:0]        code_eff;
  logic [7:0]        code_rel;
  logic [BASE_W-1:0] glyph_base;
  logic [MOD_W-1:0]  mod_div;
  logic [MOD_W-1:0]  mod_red;
  logic [MOD_W-1:0]  fa_inc;
  logic [4:0]        pg;
  logic [7:0]        xs;
  logic [12:0]       pg_prod;
  logic [IDX_W-1:0]  idx_full;
  logic              hit;
  logic [15:0]       gsh;
  logic [15:0]       msh;
  logic [7:0]        sel_g;
  logic [7:0]        sel_m;
  logic              last_col;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign raddr_ext  = IDX_W'(item_r.read_addr);
  assign faddr_ext  = MOD_W'(item_r.font_addr);
  assign fill_n     = 12'(width_r) * 12'(height_r[6:3]);
  assign code_eff   = ((item_r.char_code < first_r) || (item_r.char_code > last_r)) ?
                      SUBST_CODE : item_r.char_code;
  assign code_rel   = code_eff - first_r;
  assign glyph_base = BASE_W'(code_rel) * BASE_W'(gcols_r);

  // Shared compare-subtract step for the modulo reduction
  assign mod_div = MOD_W'(FONT_BYTES) << k_r;
  assign mod_red = (fa_r >= mod_div) ? (fa_r - mod_div) : fa_r;
  assign fa_inc  = (fa_r + MOD_W'(1) == MOD_W'(FONT_BYTES)) ? '0 : (fa_r + MOD_W'(1));

  // Page byte address and masks for the current column and pass
  assign pg       = pass_r ? (item_r.y_coord[7:3] + 5'd1) : item_r.y_coord[7:3];
  assign xs       = item_r.x_coord + {4'b0, col_r};
  assign pg_prod  = 13'(pg) * 13'(width_r);
  assign idx_full = IDX_W'(pg_prod) + IDX_W'(xs);
  assign hit      = (xs < width_r) && (idx_full < IDX_W'(FRAME_BYTES));
  assign gsh      = {8'h00, glyph_r} << item_r.y_coord[2:0];
  assign msh      = {8'h00, dmask_r} << item_r.y_coord[2:0];
  assign sel_g    = pass_r ? gsh[15:8] : gsh[7:0];
  assign sel_m    = pass_r ? msh[15:8] : msh[7:0];
  assign last_col = (col_r + 4'd1 == cols_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (item_r.opcode)
          OP_FILL:  state_nxt = S_FILL;
          OP_PIXEL: state_nxt = S_PG_RD;
          OP_CHAR:  state_nxt = (gcols_r == 4'd0) ? S_DONE : S_MOD;
          OP_READ:  state_nxt = S_RDATA;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_FILL: begin
        if (fill_cnt_r == fill_end_r) state_nxt = clr_r ? S_IDLE : S_DONE;
      end
      S_MOD: begin
        if (k_r == '0) state_nxt = S_FONT;
      end
      S_FONT:  state_nxt = S_GLYPH;
      S_GLYPH: state_nxt = S_PG_RD;
      S_PG_RD: state_nxt = S_PG_WR;
      S_PG_WR: begin
        if (!pass_r) begin
          state_nxt = S_PG_RD;
        end else begin
          state_nxt = last_col ? S_DONE : S_FONT;
        end
      end
      S_RDATA: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    fill_cnt_nxt  = fill_cnt_r;
    fill_end_nxt  = fill_end_r;
    fill_val_nxt  = fill_val_r;
    clr_nxt       = clr_r;
    fa_nxt        = fa_r;
    k_nxt         = k_r;
    col_nxt       = col_r;
    cols_nxt      = cols_r;
    pass_nxt      = pass_r;
    glyph_nxt     = glyph_r;
    dmask_nxt     = dmask_r;
    idx_nxt       = idx_r;
    wen_nxt       = wen_r;
    wmask_nxt     = wmask_r;
    wbits_nxt     = wbits_r;
    res_data_nxt  = res_data_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    frame_we      = 1'b0;
    frame_waddr   = fill_cnt_r[FRAME_AW-1:0];
    frame_wdata   = fill_val_r;
    frame_raddr   = idx_full[FRAME_AW-1:0];
    font_we       = 1'b0;
    font_waddr    = faddr_ext[FONT_AW-1:0];

    // Drop the result once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_DECODE: begin
        res_data_nxt = 8'h00;
        col_nxt      = 4'd0;
        pass_nxt     = 1'b0;
        case (item_r.opcode)
          OP_FILL: begin
            fill_cnt_nxt = '0;
            fill_val_nxt = item_r.color ? FILL_WHITE : FILL_BLACK;
            clr_nxt      = 1'b0;
            if ({1'b0, fill_n} >= 13'(FRAME_BYTES)) begin
              fill_end_nxt = CNT_W'(FRAME_BYTES);
            end else begin
              fill_end_nxt = CNT_W'(fill_n);
            end
          end
          OP_PIXEL: begin
            glyph_nxt = 8'h01;
            dmask_nxt = 8'h01;
            cols_nxt  = 4'd1;
          end
          OP_CHAR: begin
            fa_nxt    = MOD_W'(glyph_base);
            k_nxt     = K_W'(MOD_SH);
            dmask_nxt = 8'hFF;
            cols_nxt  = (gcols_r > 4'd8) ? 4'd8 : gcols_r;
          end
          OP_FONT_WR: begin
            font_we = (faddr_ext < MOD_W'(FONT_BYTES));
          end
          OP_READ: begin
            frame_raddr = raddr_ext[FRAME_AW-1:0];
            rd_ok_nxt   = (raddr_ext < IDX_W'(FRAME_BYTES));
          end
          default: ;
        endcase
      end
      S_FILL: begin
        // Write one byte a cycle until the end count
        if (fill_cnt_r != fill_end_r) begin
          frame_we     = 1'b1;
          fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
        end
      end
      S_MOD: begin
        fa_nxt = mod_red;
        k_nxt  = k_r - K_W'(1);
      end
      S_GLYPH: begin
        glyph_nxt = font_rdata;
      end
      S_PG_RD: begin
        // Read the page byte and latch its merge mask
        idx_nxt   = idx_full[FRAME_AW-1:0];
        wen_nxt   = hit;
        wmask_nxt = sel_m & row_clip(pg, height_r);
        wbits_nxt = item_r.color ? sel_g : ~sel_g;
      end
      S_PG_WR: begin
        frame_we    = wen_r;
        frame_waddr = idx_r;
        frame_wdata = (frame_rdata & ~wmask_r) | (wbits_r & wmask_r);
        if (!pass_r) begin
          pass_nxt = 1'b1;
        end else begin
          pass_nxt = 1'b0;
          col_nxt  = col_r + 4'd1;
          fa_nxt   = fa_inc;
        end
      end
      S_RDATA: begin
        res_data_nxt = rd_ok_r ? frame_rdata : 8'h00;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.read_data = res_data_r;
          out_data_nxt.done_op   = item_r.opcode;
        end
      end
      default: ;
    endcase
  end

  // Sequencer and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_cnt_r  <= '0;
      fill_end_r  <= CNT_W'(FRAME_BYTES);
      fill_val_r  <= FILL_BLACK;
      clr_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_end_r  <= fill_end_nxt;
      fill_val_r  <= fill_val_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 7'd64;
      gcols_r  <= 4'd6;
      first_r  <= 8'd32;
      last_r   <= 8'd126;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata[6:0];
        CFG_GCOLS:  gcols_r  <= cfg_wdata[3:0];
        CFG_FIRST:  first_r  <= cfg_wdata;
        CFG_LAST:   last_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    fa_r       <= fa_nxt;
    k_r        <= k_nxt;
    col_r      <= col_nxt;
    cols_r     <= cols_nxt;
    pass_r     <= pass_nxt;
    glyph_r    <= glyph_nxt;
    dmask_r    <= dmask_nxt;
    idx_r      <= idx_nxt;
    wen_r      <= wen_nxt;
    wmask_r    <= wmask_nxt;
    wbits_r    <= wbits_nxt;
    res_data_r <= res_data_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  mpfb_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  mpfb_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (item_r.font_byte),
    .raddr (fa_r[FONT_AW-1:0]),
    .rdata (font_rdata)
  );

endmodule

[rtl/mpfb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mpfb_checker.sv]
// Port-level checker for the page framebuffer text block, with its bind.
module mpfb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mpfb_pkg::out_item_t out_data
);

  import mpfb_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Only a read returns data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.done_op != OP_READ) |-> out_data.read_data == 8'h00)
    else $error("nonzero read_data on a non-read result");

  // Clearing pass blocks input right after reset
  a_clear_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  // One operation at a time
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

endmodule

bind mono_page_framebuffer_text_core mpfb_checker u_mpfb_checker (.*);
